// File: rtl/wfmf_pkg.sv
// ----------------------------------------------------------------------------
// wfmf_pkg
// shared types, sizes and state codes of the word frequency mode finder
// ----------------------------------------------------------------------------
package wfmf_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int NAME_CHARS  = 50;
	localparam int COUNT_BITS  = 16;

	localparam int ENT_W  = $clog2(MAX_ENTRIES);
	localparam int USED_W = $clog2(MAX_ENTRIES + 1);
	localparam int LEN_W  = $clog2(NAME_CHARS + 1);
	localparam int CH_W   = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
	localparam int ST_D   = MAX_ENTRIES * NAME_CHARS;
	localparam int ST_AW  = $clog2(ST_D);
	localparam int BASE_W = $clog2(ST_D + 1);

	typedef struct packed {
		logic       func;
		logic [7:0] character;
		logic       word_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  name_char;
		logic [15:0] frequency;
		logic        table_overflow;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F_LEN,
		ST_F_LENCHK,
		ST_F_CHR,
		ST_F_CHRCHK,
		ST_F_INC,
		ST_APPEND,
		ST_A_RD,
		ST_A_WR,
		ST_R_RD,
		ST_R_CHK,
		ST_R_LEN,
		ST_R_LENCAP,
		ST_O_RD,
		ST_O_WR,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic buf_wr;
		logic wlen_clr;
		logic scan_rst;
		logic e_next;
		logic k_clr;
		logic k_inc;
		logic cnt_wr_inc;
		logic name_wr;
		logic entry_new;
		logic ovf_set;
		logic best_chk;
		logic go_best;
		logic len_cap;
		logic out_load;
		logic out_empty;
	} ctl_cmd_t;

	typedef struct packed {
		logic e_at_used;
		logic e_last;
		logic used_zero;
		logic used_full;
		logic len_match;
		logic chr_match;
		logic k_last_w;
		logic k_last_o;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/wfmf_ram.sv
// ----------------------------------------------------------------------------
// wfmf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wfmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: rtl/wfmf_ctrl.sv
// ----------------------------------------------------------------------------
// wfmf_ctrl
// sequencer for word capture, table search, append and report
// ----------------------------------------------------------------------------
module wfmf_ctrl import wfmf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_data,
	output logic     in_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!in_data.func) begin
						cmd.buf_wr = 1'b1;
						if (in_data.word_end) begin
							cmd.scan_rst = 1'b1;
							state_d      = ST_F_LEN;
						end
					end else if (stat.used_zero) begin
						state_d = ST_EMPTY;
					end else begin
						cmd.scan_rst = 1'b1;
						state_d      = ST_R_RD;
					end
				end
			end
			ST_F_LEN: begin
				state_d = stat.e_at_used ? ST_APPEND : ST_F_LENCHK;
			end
			ST_F_LENCHK: begin
				if (stat.len_match) begin
					cmd.k_clr = 1'b1;
					state_d   = ST_F_CHR;
				end else begin
					cmd.e_next = 1'b1;
					state_d    = ST_F_LEN;
				end
			end
			ST_F_CHR: begin
				state_d = ST_F_CHRCHK;
			end
			ST_F_CHRCHK: begin
				if (!stat.chr_match) begin
					cmd.e_next = 1'b1;
					state_d    = ST_F_LEN;
				end else if (stat.k_last_w) begin
					state_d = ST_F_INC;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = ST_F_CHR;
				end
			end
			ST_F_INC: begin
				cmd.cnt_wr_inc = 1'b1;
				cmd.wlen_clr   = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_APPEND: begin
				if (stat.used_full) begin
					cmd.ovf_set  = 1'b1;
					cmd.wlen_clr = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.k_clr = 1'b1;
					state_d   = ST_A_RD;
				end
			end
			ST_A_RD: begin
				state_d = ST_A_WR;
			end
			ST_A_WR: begin
				cmd.name_wr = 1'b1;
				if (stat.k_last_w) begin
					cmd.entry_new = 1'b1;
					cmd.wlen_clr  = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = ST_A_RD;
				end
			end
			ST_R_RD: begin
				state_d = ST_R_CHK;
			end
			ST_R_CHK: begin
				cmd.best_chk = 1'b1;
				if (stat.e_last) begin
					cmd.go_best = 1'b1;
					cmd.k_clr   = 1'b1;
					state_d     = ST_R_LEN;
				end else begin
					cmd.e_next = 1'b1;
					state_d    = ST_R_RD;
				end
			end
			ST_R_LEN: begin
				state_d = ST_R_LENCAP;
			end
			ST_R_LENCAP: begin
				cmd.len_cap = 1'b1;
				state_d     = ST_O_WR;
			end
			ST_O_RD: begin
				state_d = ST_O_WR;
			end
			ST_O_WR: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.k_last_o) begin
						state_d = ST_IDLE;
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = ST_O_RD;
					end
				end
			end
			ST_EMPTY: begin
				if (stat.out_free) begin
					cmd.out_empty = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_name_wr_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.name_wr |-> $past(state_q) == ST_A_RD)
		else $error("name write without preceding buffer read");

	a_report_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load || cmd.out_empty) |-> stat.out_free)
		else $error("result loaded into occupied output slot");

	a_one_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && !in_data.func && in_data.word_end)
		|=> state_q == ST_F_LEN)
		else $error("word end did not start a search");

endmodule

// File: rtl/wfmf_dpath.sv
// ----------------------------------------------------------------------------
// wfmf_dpath
// word buffer, entry tables, scan registers and output register
// ----------------------------------------------------------------------------
module wfmf_dpath import wfmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] character,
	input  ctl_cmd_t  cmd,
	output dp_stat_t  stat,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic [LEN_W-1:0]      wlen_q;
	logic [USED_W-1:0]     used_q;
	logic                  ovf_q;
	logic [USED_W-1:0]     e_q;
	logic [BASE_W-1:0]     base_q;
	logic [LEN_W-1:0]      k_q;
	logic [USED_W-1:0]     best_q;
	logic [BASE_W-1:0]     best_base_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [LEN_W-1:0]      len_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [7:0]            wbuf_rd;
	logic [7:0]            name_rd;
	logic [LEN_W-1:0]      len_rd;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic                  wbuf_we;
	logic [ST_AW-1:0]      name_addr;
	logic                  cnt_we;
	logic [COUNT_BITS-1:0] cnt_wd;
	logic                  better;
	logic [USED_W-1:0]     nb_e;
	logic [BASE_W-1:0]     nb_base;
	logic [31:0]           cnt32;
	logic [15:0]           freq;

	assign wbuf_we   = cmd.buf_wr && (wlen_q < LEN_W'(NAME_CHARS));
	assign name_addr = base_q[ST_AW-1:0] + ST_AW'(k_q);
	assign cnt_we    = cmd.cnt_wr_inc || cmd.entry_new;
	// counter saturates at all ones
	assign cnt_wd    = cmd.entry_new ? COUNT_BITS'(1) :
	                   ((&cnt_rd) ? cnt_rd : cnt_rd + COUNT_BITS'(1));

	wfmf_ram #(.WIDTH(8), .DEPTH(NAME_CHARS)) u_wbuf (
		.clk     (clk),
		.wr_en   (wbuf_we),
		.wr_addr (wlen_q[CH_W-1:0]),
		.wr_data (character),
		.rd_addr (k_q[CH_W-1:0]),
		.rd_data (wbuf_rd)
	);

	wfmf_ram #(.WIDTH(8), .DEPTH(ST_D)) u_names (
		.clk     (clk),
		.wr_en   (cmd.name_wr),
		.wr_addr (name_addr),
		.wr_data (wbuf_rd),
		.rd_addr (name_addr),
		.rd_data (name_rd)
	);

	wfmf_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES)) u_lens (
		.clk     (clk),
		.wr_en   (cmd.entry_new),
		.wr_addr (e_q[ENT_W-1:0]),
		.wr_data (wlen_q),
		.rd_addr (e_q[ENT_W-1:0]),
		.rd_data (len_rd)
	);

	wfmf_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_ENTRIES)) u_cnts (
		.clk     (clk),
		.wr_en   (cnt_we),
		.wr_addr (e_q[ENT_W-1:0]),
		.wr_data (cnt_wd),
		.rd_addr (e_q[ENT_W-1:0]),
		.rd_data (cnt_rd)
	);

	// strictly greater keeps the lowest index on ties
	assign better  = (e_q == '0) || (cnt_rd > best_cnt_q);
	assign nb_e    = better ? e_q : best_q;
	assign nb_base = better ? base_q : best_base_q;

	assign cnt32 = 32'(cnt_rd) > 32'hFFFF ? 32'hFFFF : 32'(best_cnt_q);
	assign freq  = (32'(best_cnt_q) > 32'hFFFF) ? 16'hFFFF : cnt32[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q      <= '0;
			used_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wlen_clr) begin
				wlen_q <= '0;
			end else if (wbuf_we) begin
				wlen_q <= wlen_q + LEN_W'(1);
			end
			if (cmd.entry_new) begin
				used_q <= used_q + USED_W'(1);
			end
			if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (cmd.out_load || cmd.out_empty) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rst) begin
			e_q    <= '0;
			base_q <= '0;
		end else if (cmd.e_next) begin
			e_q    <= e_q + USED_W'(1);
			base_q <= base_q + BASE_W'(NAME_CHARS);
		end else if (cmd.go_best) begin
			e_q    <= nb_e;
			base_q <= nb_base;
		end
		if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + LEN_W'(1);
		end
		if (cmd.best_chk && better) begin
			best_q      <= e_q;
			best_base_q <= base_q;
			best_cnt_q  <= cnt_rd;
		end
		if (cmd.len_cap) begin
			len_q <= len_rd;
		end
		if (cmd.out_load) begin
			out_q.name_char      <= name_rd;
			out_q.frequency      <= freq;
			out_q.table_overflow <= ovf_q;
			out_q.last           <= ((LEN_W + 1)'(k_q) + 1'b1) == (LEN_W + 1)'(len_q);
		end else if (cmd.out_empty) begin
			out_q.name_char      <= '0;
			out_q.frequency      <= '0;
			out_q.table_overflow <= ovf_q;
			out_q.last           <= 1'b1;
		end
	end

	always_comb begin
		stat.e_at_used = (e_q == used_q);
		stat.e_last    = ((e_q + USED_W'(1)) == used_q);
		stat.used_zero = (used_q == '0);
		stat.used_full = (used_q == USED_W'(MAX_ENTRIES));
		stat.len_match = (len_rd == wlen_q);
		stat.chr_match = (name_rd == wbuf_rd);
		stat.k_last_w  = (((LEN_W + 1)'(k_q) + 1'b1) == (LEN_W + 1)'(wlen_q));
		stat.k_last_o  = (((LEN_W + 1)'(k_q) + 1'b1) == (LEN_W + 1)'(len_q));
		stat.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.entry_new |-> used_q < USED_W'(MAX_ENTRIES))
		else $error("entry appended to a full table");

	a_wlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wlen_q <= LEN_W'(NAME_CHARS))
		else $error("word length beyond name size");

	a_wlen_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wlen_clr |=> wlen_q == '0)
		else $error("word length not cleared after word end");

endmodule

// File: rtl/word_frequency_mode_finder_unit.sv
// ----------------------------------------------------------------------------
// word_frequency_mode_finder_unit
// word histogram that reports the most frequent stored word
// ----------------------------------------------------------------------------
// usage
//   in channel: one beat per character (func 0) with word_end on the last
//   character, or a report request (func 1). in_stall is low only while the
//   sequencer is idle, so one beat is taken at a time.
//   a character beat without word_end is stored in the word buffer. a word
//   end walks the table entry by entry: a length read and check per entry,
//   a read and check per compared character, then a count bump on a match
//   or a read and write per character to append the word. in the worst
//   case every entry is compared in full, as the name ram has a single
//   read port. a report scans all counts, a read and check per entry,
//   then sends the best name one beat per character, each beat carrying
//   count, overflow flag and last.
//   an empty table gives a single beat with count 0 and last set.
//   out channel: an output register holds each beat; while out_stall is
//   high the beat holds and the sequencer waits before loading the next.
//   reset clears the entry count, word length and overflow flag; the rams
//   are not cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
module word_frequency_mode_finder_unit import wfmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// sequencer: owns the input handshake and steps the datapath
	wfmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: word buffer, name/length/count rams, output register
	wfmf_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.character (in_data.character),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: sim/tb_word_frequency_mode_finder_unit.sv
// ----------------------------------------------------------------------------
// tb_word_frequency_mode_finder_unit
// self-checking bench for the word histogram and most frequent word report
// ----------------------------------------------------------------------------
// a behavioral histogram in the bench follows every accepted input beat and
// queues the report beats it expects; each output beat is checked field by
// field against the oldest one. directed tests cover the empty report, byte
// extremes, ties, long words, a report in the middle of a word and a full
// table; a random phase then sends words from a small vocabulary with noise,
// while both sides idle at random and the receiver once holds off for long.
// ----------------------------------------------------------------------------
module tb_word_frequency_mode_finder_unit;
	import wfmf_pkg::*;

	localparam int       CLK_HALF    = 4;
	localparam int       RESET_CYC   = 6;
	localparam int       RAND_ITEMS  = 80;
	localparam int       VOCAB_SIZE  = 24;
	localparam int       SETTLE_CYC  = 7000;
	localparam longint   CYCLE_LIMIT = 1500000;
	localparam logic     FN_CHAR     = 1'b0;
	localparam logic     FN_REPORT   = 1'b1;
	localparam int       FREQ_MAX    = 65535;
	localparam int       CNT_MAX     = (1 << COUNT_BITS) - 1;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	// behavioral copy of the histogram
	logic [7:0]  hist_name [MAX_ENTRIES][NAME_CHARS];
	int          hist_len  [MAX_ENTRIES];
	int          hist_cnt  [MAX_ENTRIES];
	int          hist_used;
	logic [7:0]  cur_word  [NAME_CHARS];
	int          cur_len;
	logic        dropped_seen;

	out_item_t   report_q[$];

	// vocabulary for the random phase
	logic [7:0]  vocab     [VOCAB_SIZE][64];
	int          vocab_len [VOCAB_SIZE];

	int          n_errors;
	int          n_items;
	int          n_words;
	int          n_reports;
	int          n_checked;
	longint      cycles = 0;
	bit          no_gaps;
	int          hold_cycles;

	word_frequency_mode_finder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// run limit in cycles, sized from the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_word_frequency_mode_finder_unit: errors");
			$finish;
		end
	end

	// closing a word: match on length and bytes, else append, else drop
	function automatic void close_word();
		int  e;
		int  k;
		bit  same;
		for (e = 0; e < hist_used; e++) begin
			if (hist_len[e] == cur_len) begin
				same = 1'b1;
				for (k = 0; k < cur_len; k++)
					if (hist_name[e][k] != cur_word[k]) same = 1'b0;
				if (same) begin
					if (hist_cnt[e] < CNT_MAX) hist_cnt[e]++;
					return;
				end
			end
		end
		if (hist_used < MAX_ENTRIES) begin
			for (k = 0; k < cur_len; k++) hist_name[hist_used][k] = cur_word[k];
			hist_len[hist_used] = cur_len;
			hist_cnt[hist_used] = 1;
			hist_used++;
		end else begin
			dropped_seen = 1'b1;
		end
	endfunction

	// advance the histogram by one accepted beat, queue any report beats
	function automatic void track_beat(in_item_t b);
		int        best;
		int        e;
		int        k;
		out_item_t r;
		if (b.func == FN_CHAR) begin
			// bytes past the name length are dropped
			if (cur_len < NAME_CHARS) begin
				cur_word[cur_len] = b.character;
				cur_len++;
			end
			if (b.word_end) begin
				close_word();
				cur_len = 0;
			end
			return;
		end
		if (hist_used == 0) begin
			r.name_char      = 8'h00;
			r.frequency      = 16'h0000;
			r.table_overflow = dropped_seen;
			r.last           = 1'b1;
			report_q.push_back(r);
			return;
		end
		// lowest index wins ties
		best = 0;
		for (e = 1; e < hist_used; e++)
			if (hist_cnt[e] > hist_cnt[best]) best = e;
		for (k = 0; k < hist_len[best]; k++) begin
			r.name_char      = hist_name[best][k];
			r.frequency      = (hist_cnt[best] > FREQ_MAX) ? 16'hFFFF : 16'(hist_cnt[best]);
			r.table_overflow = dropped_seen;
			r.last           = (k + 1 == hist_len[best]);
			report_q.push_back(r);
		end
	endfunction

	// one input beat: random gap, offer, hold until taken
	task automatic send_beat(logic fn, logic [7:0] ch, logic wend);
		int       gap;
		in_item_t b;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		b.func      = fn;
		b.character = ch;
		b.word_end  = wend;
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (in_stall);
		track_beat(b);
		n_items++;
		if (fn == FN_REPORT) n_reports++;
		else if (wend) n_words++;
	endtask

	task automatic send_word(logic [7:0] w [64], int len);
		int k;
		for (k = 0; k < len; k++) send_beat(FN_CHAR, w[k], k == len - 1);
	endtask

	// report beat with random ignored fields
	task automatic send_report();
		send_beat(FN_REPORT, 8'($urandom), 1'($urandom));
	endtask

	// wait until every expected beat has been seen
	task automatic drain();
		in_valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
	endtask

	// receiver: random stall before each beat, with stretches of no stall
	initial begin : receiver
		int gap;
		int run;
		out_stall = 1'b1;
		run = 0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			// every 32 beats flip a coin on a stall-free stretch
			if (run == 0) run = $urandom_range(0, 1) ? 32 : -32;
			if (run > 0) begin
				gap = 0;
				run--;
			end else begin
				gap = $urandom_range(0, 15);
				run++;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid && hold_cycles == 0);
		end
	end

	// checker: compare every accepted output beat with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (report_q.size() == 0) begin
				$display("%0t: unexpected beat, got %h", $time, out_data);
				n_errors++;
			end else begin
				want = report_q.pop_front();
				n_checked++;
				if (out_data.name_char !== want.name_char) begin
					$display("%0t: name_char expected %h got %h",
						$time, want.name_char, out_data.name_char);
					n_errors++;
				end
				if (out_data.frequency !== want.frequency) begin
					$display("%0t: frequency expected %0d got %0d",
						$time, want.frequency, out_data.frequency);
					n_errors++;
				end
				if (out_data.table_overflow !== want.table_overflow) begin
					$display("%0t: table_overflow expected %b got %b",
						$time, want.table_overflow, out_data.table_overflow);
					n_errors++;
				end
				if (out_data.last !== want.last) begin
					$display("%0t: last expected %b got %b",
						$time, want.last, out_data.last);
					n_errors++;
				end
			end
		end
	end

	// report on an empty table gives one zero beat
	task automatic test_empty_report();
		send_report();
		drain();
	endtask

	// byte extremes, repeats and a tie
	task automatic test_extremes_and_ties();
		logic [7:0] w [64];
		w[0] = 8'h00;
		send_word(w, 1);
		send_report();
		w[0] = 8'hFF;
		send_word(w, 1);
		send_word(w, 1);
		send_report();
		// bring the first word level, lowest index must win
		w[0] = 8'h00;
		send_word(w, 1);
		send_report();
		// same length, last byte differs
		w[0] = 8'hFF; w[1] = 8'h00;
		send_word(w, 2);
		w[1] = 8'h01;
		send_word(w, 2);
		drain();
	endtask

	// words at, past and far past the name length
	task automatic test_long_words();
		logic [7:0] w [64];
		int         k;
		for (k = 0; k < 64; k++) w[k] = 8'($urandom);
		send_word(w, NAME_CHARS);
		send_word(w, NAME_CHARS + 1);
		send_word(w, 60);
		send_report();
		drain();
	endtask

	// report arrives while a word is half received
	task automatic test_report_mid_word();
		send_beat(FN_CHAR, 8'h5A, 1'b0);
		send_beat(FN_CHAR, 8'hA5, 1'b0);
		send_report();
		send_beat(FN_CHAR, 8'h3C, 1'b1);
		send_report();
		drain();
	endtask

	// receiver holds off long while reports keep coming, so the block backs up
	task automatic test_backpressure();
		hold_cycles = 400;
		no_gaps = 1'b1;
		repeat (4) send_report();
		send_beat(FN_CHAR, 8'h42, 1'b1);
		send_report();
		no_gaps = 1'b0;
		drain();
	endtask

	// random words from a vocabulary with noise and broken words
	task automatic test_random_traffic(int n_beats);
		logic [7:0] w [64];
		int         goal;
		int         pick;
		int         v;
		int         k;
		goal = n_items + n_beats;
		while (n_items < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				v = $urandom_range(0, VOCAB_SIZE - 1);
				for (k = 0; k < 64; k++) w[k] = vocab[v][k];
				send_word(w, vocab_len[v]);
			end else if (pick < 92) begin
				send_report();
			end else if (pick < 97) begin
				for (k = 0; k < 64; k++) w[k] = 8'($urandom);
				send_word(w, $urandom_range(1, 6));
			end else begin
				// broken word: report lands between its bytes
				send_beat(FN_CHAR, 8'($urandom), 1'b0);
				send_report();
				send_beat(FN_CHAR, 8'($urandom), 1'b1);
			end
			// stretches with no sender gaps
			if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
		end
		no_gaps = 1'b0;
		drain();
	endtask

	// fill the table, then push new words that must be dropped
	task automatic test_table_overflow();
		logic [7:0] w [64];
		int         i;
		i = 0;
		while (hist_used < MAX_ENTRIES && i < 256) begin
			w[0] = 8'hC3; w[1] = 8'(i);
			send_word(w, 2);
			i++;
		end
		send_report();
		repeat (3) begin
			w[0] = 8'h7E; w[1] = 8'(i); w[2] = 8'hE7;
			send_word(w, 3);
			i++;
		end
		send_report();
		drain();
	endtask

	initial begin : main
		int v;
		int k;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		n_errors    = 0;
		n_items     = 0;
		n_words     = 0;
		n_reports   = 0;
		n_checked   = 0;
		no_gaps     = 1'b0;
		hold_cycles = 0;
		hist_used   = 0;
		cur_len     = 0;
		dropped_seen = 1'b0;
		for (v = 0; v < VOCAB_SIZE; v++) begin
			vocab_len[v] = (v < 2) ? $urandom_range(48, 60) : $urandom_range(1, 8);
			for (k = 0; k < 64; k++) vocab[v][k] = 8'($urandom);
		end
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_report();
		test_extremes_and_ties();
		test_long_words();
		test_report_mid_word();
		test_backpressure();
		test_random_traffic(RAND_ITEMS);
		test_table_overflow();
		test_random_traffic(20);

		// a word end may still walk the table with nothing to report
		repeat (SETTLE_CYC) @(posedge clk);
		$display("covered %0d input beats: %0d words, %0d reports, %0d entries used",
			n_items, n_words, n_reports, hist_used);
		$display("checked %0d report beats, table overflow reached: %b",
			n_checked, dropped_seen);
		if (n_errors == 0 && report_q.size() == 0) begin
			$display("tb_word_frequency_mode_finder_unit: clean");
		end else begin
			$display("tb_word_frequency_mode_finder_unit: errors");
		end
		$finish;
	end

endmodule
